// ===== hw/rtl/csvt_pkg.sv =====
// Shared constants and types of the CSV stream tokenizer.
package csvt_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned ModeW = 3;

    typedef logic [ByteW-1:0] t_byte;
    typedef logic [ModeW-1:0] t_mode;

    // Delimiter and quote characters.
    localparam t_byte ChComma = 8'h2C;
    localparam t_byte ChQuote = 8'h22;
    localparam t_byte ChCr    = 8'h0D;
    localparam t_byte ChLf    = 8'h0A;

    // Whitespace skipped ahead of a cell.
    localparam t_byte ChSpace = 8'h20;
    localparam t_byte ChTab   = 8'h09;
    localparam t_byte ChVt    = 8'h0B;
    localparam t_byte ChFf    = 8'h0C;

    // Parse modes.
    localparam t_mode ModeRowStart   = 3'd0;
    localparam t_mode ModeCellLead   = 3'd1;
    localparam t_mode ModeUnquoted   = 3'd2;
    localparam t_mode ModeQuoted     = 3'd3;
    localparam t_mode ModeQuoteSeen  = 3'd4;
    localparam t_mode ModeAfterQuote = 3'd5;
    localparam t_mode ModeCrSeen     = 3'd6;

    // One result item.
    typedef struct packed {
        logic  data_valid;
        t_byte data_byte;
        logic  field_end;
        logic  row_end;
    } t_result;

endpackage

// ===== hw/rtl/csvt_stream_if.sv =====
// Valid/ready channels carrying input bytes and result items.
interface csvt_in_if;
    logic           valid;
    logic           ready;
    csvt_pkg::t_byte byte_in;
    logic           end_of_stream;

    modport source (output valid, output byte_in, output end_of_stream, input ready);
    modport sink   (input valid, input byte_in, input end_of_stream, output ready);
endinterface

interface csvt_out_if;
    logic           valid;
    logic           ready;
    logic           data_valid;
    csvt_pkg::t_byte data_byte;
    logic           field_end;
    logic           row_end;

    modport source (output valid, output data_valid, output data_byte, output field_end,
                    output row_end, input ready);
    modport sink   (input valid, input data_valid, input data_byte, input field_end,
                    input row_end, output ready);
endinterface

// ===== hw/rtl/csv_stream_tokenizer.sv =====
// Top level of the CSV stream tokenizer.
// Splits a CSV byte stream into cells and rows. Each input item is one byte
// or an end-of-stream mark; it yields zero or one result item: a content
// byte of the current cell (data_valid, data_byte), or a cell-complete mark
// (field_end) with row_end when the row closes too. Leading blanks (space,
// TAB, VT, FF) of a cell are dropped; comma ends a cell; CR, LF or CRLF end
// a row; a cell opening with a double quote may hold commas and line
// breaks, and "" inside it gives one quote. Bytes after the closing quote up
// to the next delimiter are discarded. An empty line gives one empty cell.
// End of stream closes an open row and returns to row start. Items that
// produce no result (skipped blanks, quotes, the LF of CRLF) are consumed
// silently. Throughput is one byte per clock while the consumer keeps up:
// an input register feeds the combinational decode against the 3-bit mode
// register, whose result lands in an output register. A result item passes
// through the input register and then the output register before it is
// presented. Ready only drops when both the input and output registers are
// full and the consumer is stalling.
module csv_stream_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csvt_in_if.sink    i_in,
    csvt_out_if.source o_out
);

    // Input register
    logic            r_in_valid;
    logic            n_in_valid;
    csvt_pkg::t_byte r_byte;
    logic            r_eos;

    // Parse mode, reset to row start
    csvt_pkg::t_mode r_mode;
    csvt_pkg::t_mode n_mode;

    csvt_pkg::t_mode   dec_mode;
    csvt_pkg::t_result dec_res;
    logic              dec_has_res;
    logic              out_can_load;
    logic              step;

    // the held byte is decoded once the result register can take its output
    assign step       = r_in_valid && out_can_load;
    assign i_in.ready = !r_in_valid || out_can_load;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_in.ready) begin
            n_in_valid = i_in.valid;
        end
        n_mode = step ? dec_mode : r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= csvt_pkg::ModeRowStart;
        end else begin
            r_in_valid <= n_in_valid;
            r_mode     <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.byte_in;
            r_eos  <= i_in.end_of_stream;
        end
    end

    csvt_decode u_decode (
        .i_mode      (r_mode),
        .i_byte      (r_byte),
        .i_eos       (r_eos),
        .o_next_mode (dec_mode),
        .o_res       (dec_res),
        .o_has_res   (dec_has_res)
    );

    csvt_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step && dec_has_res),
        .i_res      (dec_res),
        .o_can_load (out_can_load),
        .o_out      (o_out)
    );

endmodule

// ===== hw/rtl/csvt_decode.sv =====
// Per-byte parse step: next mode and the result item, if any.
module csvt_decode (
    input  csvt_pkg::t_mode   i_mode,
    input  csvt_pkg::t_byte   i_byte,
    input  logic              i_eos,
    output csvt_pkg::t_mode   o_next_mode,
    output csvt_pkg::t_result o_res,
    output logic              o_has_res
);

    logic            is_comma;
    logic            is_cr;
    logic            is_lf;
    logic            is_quote;
    logic            is_delim;
    logic            is_space;
    logic            do_begin;
    logic            do_after;
    csvt_pkg::t_mode stay_mode;

    assign is_comma = (i_byte == csvt_pkg::ChComma);
    assign is_cr    = (i_byte == csvt_pkg::ChCr);
    assign is_lf    = (i_byte == csvt_pkg::ChLf);
    assign is_quote = (i_byte == csvt_pkg::ChQuote);
    assign is_delim = is_comma | is_cr | is_lf;
    assign is_space = (i_byte == csvt_pkg::ChSpace) | (i_byte == csvt_pkg::ChTab) |
                      (i_byte == csvt_pkg::ChVt) | (i_byte == csvt_pkg::ChFf);

    always_comb begin
        o_next_mode = csvt_pkg::ModeRowStart;
        o_res       = '0;
        do_begin    = 1'b0;
        do_after    = 1'b0;
        stay_mode   = csvt_pkg::ModeCellLead;

        if (i_eos) begin
            // close any open row; a pending CR or row start gives nothing
            if ((i_mode == csvt_pkg::ModeCellLead) || (i_mode == csvt_pkg::ModeUnquoted) ||
                (i_mode == csvt_pkg::ModeQuoted) || (i_mode == csvt_pkg::ModeQuoteSeen) ||
                (i_mode == csvt_pkg::ModeAfterQuote)) begin
                o_res.field_end = 1'b1;
                o_res.row_end   = 1'b1;
            end
        end else begin
            case (i_mode)
                csvt_pkg::ModeUnquoted: begin
                    if (is_delim) begin
                        do_after  = 1'b1;
                        stay_mode = csvt_pkg::ModeUnquoted;
                    end else begin
                        o_next_mode      = csvt_pkg::ModeUnquoted;
                        o_res.data_valid = 1'b1;
                        o_res.data_byte  = i_byte;
                    end
                end
                csvt_pkg::ModeQuoted: begin
                    if (is_quote) begin
                        o_next_mode = csvt_pkg::ModeQuoteSeen;
                    end else begin
                        o_next_mode      = csvt_pkg::ModeQuoted;
                        o_res.data_valid = 1'b1;
                        o_res.data_byte  = i_byte;
                    end
                end
                csvt_pkg::ModeQuoteSeen: begin
                    if (is_quote) begin
                        // doubled quote
                        o_next_mode      = csvt_pkg::ModeQuoted;
                        o_res.data_valid = 1'b1;
                        o_res.data_byte  = csvt_pkg::ChQuote;
                    end else begin
                        do_after  = 1'b1;
                        stay_mode = csvt_pkg::ModeAfterQuote;
                    end
                end
                csvt_pkg::ModeAfterQuote: begin
                    do_after  = 1'b1;
                    stay_mode = csvt_pkg::ModeAfterQuote;
                end
                csvt_pkg::ModeCrSeen: begin
                    if (is_lf) begin
                        o_next_mode = csvt_pkg::ModeRowStart;   // CRLF
                    end else begin
                        do_begin = 1'b1;
                    end
                end
                default: begin
                    do_begin = 1'b1;   // row start, cell lead, unused code
                end
            endcase

            if (do_begin) begin
                if (is_delim) begin
                    do_after  = 1'b1;
                    stay_mode = csvt_pkg::ModeCellLead;
                end else if (is_space) begin
                    o_next_mode = csvt_pkg::ModeCellLead;
                end else if (is_quote) begin
                    o_next_mode = csvt_pkg::ModeQuoted;
                end else begin
                    o_next_mode      = csvt_pkg::ModeUnquoted;
                    o_res.data_valid = 1'b1;
                    o_res.data_byte  = i_byte;
                end
            end

            if (do_after) begin
                if (is_comma) begin
                    o_next_mode     = csvt_pkg::ModeCellLead;
                    o_res.field_end = 1'b1;
                end else if (is_cr) begin
                    o_next_mode     = csvt_pkg::ModeCrSeen;
                    o_res.field_end = 1'b1;
                    o_res.row_end   = 1'b1;
                end else if (is_lf) begin
                    o_next_mode     = csvt_pkg::ModeRowStart;
                    o_res.field_end = 1'b1;
                    o_res.row_end   = 1'b1;
                end else begin
                    o_next_mode = stay_mode;
                end
            end
        end
    end

    assign o_has_res = o_res.data_valid | o_res.field_end | o_res.row_end;

endmodule

// ===== hw/rtl/csvt_out_reg.sv =====
// Result register driving the output channel.
module csvt_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  csvt_pkg::t_result i_res,
    output logic              o_can_load,
    csvt_out_if.source        o_out
);

    logic              r_valid;
    logic              n_valid;
    csvt_pkg::t_result r_res;

    // free, or emptied by the consumer this cycle
    assign o_can_load = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_can_load) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.data_valid = r_res.data_valid;
    assign o_out.data_byte  = r_res.data_byte;
    assign o_out.field_end  = r_res.field_end;
    assign o_out.row_end    = r_res.row_end;

endmodule
